[hdl/ntrp_pkg.sv]
`default_nettype none
package ntrp_pkg;

   localparam int MAX_RECORDS_DEF = 128;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [7:0] TLV_TAG  = 8'h03;
   localparam logic [7:0] TLV_TERM = 8'hFE;
   localparam logic [7:0] TLV_LONG = 8'hFF;
   localparam logic [7:0] TNF_MASK = 8'h07;

   localparam int FLAG_SR_BIT = 4;
   localparam int FLAG_IL_BIT = 3;

   typedef enum logic [3:0] {
      ROLE_SKIP    = 4'd0,
      ROLE_TAG     = 4'd1,
      ROLE_TLEN    = 4'd2,
      ROLE_HDR     = 4'd3,
      ROLE_TYPELEN = 4'd4,
      ROLE_PAYLEN  = 4'd5,
      ROLE_IDLEN   = 4'd6,
      ROLE_TYPE    = 4'd7,
      ROLE_ID      = 4'd8,
      ROLE_PAY     = 4'd9,
      ROLE_TERM    = 4'd10
   } role_type;

   typedef enum logic [2:0] {
      TP_TAG = 3'd0,
      TP_L0  = 3'd1,
      TP_L1  = 3'd2,
      TP_L2  = 3'd3,
      TP_VAL = 3'd4
   } tlv_phase_type;

   typedef enum logic [3:0] {
      RP_HDR   = 4'd0,
      RP_TLEN  = 4'd1,
      RP_PL0   = 4'd2,
      RP_PL1   = 4'd3,
      RP_PL2   = 4'd4,
      RP_PL3   = 4'd5,
      RP_IDLEN = 4'd6,
      RP_TYPE  = 4'd7,
      RP_ID    = 4'd8,
      RP_PAY   = 4'd9
   } rec_phase_type;

   // One classified byte as it travels from front to back.
   typedef struct packed {
      logic [7:0] data;
      logic       buf_start;
      logic       buf_end;
      logic       is_tag;
      logic       is_term;
      logic       is_long;
      logic       is_zero;
   } item_type;

endpackage
`default_nettype wire

[hdl/ntrp_front.sv]
`default_nettype none
module ntrp_front
   import ntrp_pkg::*;
(
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_buffer_start,
   input  wire logic       req_buffer_end,
   input  wire logic       q_full,
   output logic            q_push,
   output item_type        q_item
);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Decode the byte codes once, up front.
   always_comb begin
      q_item.data      = req_data_byte;
      q_item.buf_start = req_buffer_start;
      q_item.buf_end   = req_buffer_end;
      q_item.is_tag    = (req_data_byte == TLV_TAG);
      q_item.is_term   = (req_data_byte == TLV_TERM);
      q_item.is_long   = (req_data_byte == TLV_LONG);
      q_item.is_zero   = (req_data_byte == 8'h00);
   end

endmodule
`default_nettype wire

[hdl/ntrp_queue.sv]
`default_nettype none
module ntrp_queue
   import ntrp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output item_type      head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

[hdl/ntrp_back.sv]
`default_nettype none
module ntrp_back
   import ntrp_pkg::*;
#(
   parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_not_empty,
   input  wire item_type q_head,
   output logic          q_pop,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output logic [3:0]    rsp_byte_role,
   output logic [7:0]    rsp_record_index,
   output logic          rsp_record_done,
   output logic [7:0]    rsp_header_byte,
   output logic [7:0]    rsp_type_length,
   output logic [7:0]    rsp_id_length,
   output logic [31:0]   rsp_payload_length,
   output logic          rsp_report_valid,
   output logic          rsp_report_status,
   output logic [7:0]    rsp_report_count
);

   localparam logic [7:0] MAX_CNT = 8'(MAX_RECORDS);

   tlv_phase_type tlv_ph_ff, tlv_ph_in;
   rec_phase_type rec_ph_ff, rec_ph_in;
   logic [15:0]   tlv_len_ff, tlv_len_in;
   logic [15:0]   tlv_seen_ff, tlv_seen_in;
   logic [7:0]    hdr_ff, hdr_in;
   logic [7:0]    tlen_ff, tlen_in;
   logic [7:0]    idlen_ff, idlen_in;
   logic [31:0]   plen_ff, plen_in;
   logic [31:0]   fcnt_ff, fcnt_in;
   logic [7:0]    found_ff, found_in;
   logic          fin_ff, fin_in;
   logic          rsp_valid_ff;

   role_type      role;
   logic [7:0]    found_s;
   logic          fin_s;
   logic          done, rep, status;
   logic          after_len, go_field, allow_type, allow_id, complete;
   logic [31:0]   fcnt_inc;
   logic [15:0]   long_len;

   assign q_pop     = q_not_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign fcnt_inc  = fcnt_ff + 32'd1;
   assign long_len  = {tlv_len_ff[7:0], q_head.data};

   always_comb begin
      tlv_ph_in   = tlv_ph_ff;
      rec_ph_in   = rec_ph_ff;
      tlv_len_in  = tlv_len_ff;
      tlv_seen_in = tlv_seen_ff;
      hdr_in      = hdr_ff;
      tlen_in     = tlen_ff;
      idlen_in    = idlen_ff;
      plen_in     = plen_ff;
      fcnt_in     = fcnt_ff;
      role        = ROLE_SKIP;
      done        = 1'b0;
      rep         = 1'b0;
      status      = 1'b0;
      after_len   = 1'b0;
      go_field    = 1'b0;
      allow_type  = 1'b1;
      allow_id    = 1'b1;
      complete    = 1'b0;

      found_s = q_head.buf_start ? 8'd0 : found_ff;
      fin_s   = q_head.buf_start ? 1'b0 : fin_ff;
      fin_in  = fin_s;

      if (!fin_s) begin
         unique case (tlv_ph_ff)
            TP_TAG: begin
               if (q_head.is_tag) begin
                  role        = ROLE_TAG;
                  tlv_seen_in = '0;
                  tlv_ph_in   = TP_L0;
               end else if (q_head.is_term) begin
                  role   = ROLE_TERM;
                  fin_in = 1'b1;
                  rep    = 1'b1;
               end
            end
            TP_L0: begin
               role = ROLE_TLEN;
               if (q_head.is_long) begin
                  tlv_len_in = '0;
                  tlv_ph_in  = TP_L1;
               end else begin
                  tlv_len_in = {8'd0, q_head.data};
                  tlv_ph_in  = q_head.is_zero ? TP_TAG : TP_VAL;
               end
            end
            TP_L1: begin
               role       = ROLE_TLEN;
               tlv_len_in = {8'd0, q_head.data};
               tlv_ph_in  = TP_L2;
            end
            TP_L2: begin
               role       = ROLE_TLEN;
               tlv_len_in = long_len;
               tlv_ph_in  = (long_len != '0) ? TP_VAL : TP_TAG;
            end
            TP_VAL: begin
               unique case (rec_ph_ff)
                  RP_HDR: begin
                     role      = ROLE_HDR;
                     hdr_in    = q_head.data;
                     tlen_in   = '0;
                     idlen_in  = '0;
                     plen_in   = '0;
                     fcnt_in   = '0;
                     rec_ph_in = RP_TLEN;
                  end
                  RP_TLEN: begin
                     role      = ROLE_TYPELEN;
                     tlen_in   = q_head.data;
                     rec_ph_in = RP_PL0;
                  end
                  RP_PL0: begin
                     role    = ROLE_PAYLEN;
                     plen_in = {24'd0, q_head.data};
                     if (!hdr_ff[FLAG_SR_BIT]) begin
                        rec_ph_in = RP_PL1;
                     end else begin
                        after_len = 1'b1;
                     end
                  end
                  RP_PL1: begin
                     role      = ROLE_PAYLEN;
                     plen_in   = {plen_ff[23:0], q_head.data};
                     rec_ph_in = RP_PL2;
                  end
                  RP_PL2: begin
                     role      = ROLE_PAYLEN;
                     plen_in   = {plen_ff[23:0], q_head.data};
                     rec_ph_in = RP_PL3;
                  end
                  RP_PL3: begin
                     role      = ROLE_PAYLEN;
                     plen_in   = {plen_ff[23:0], q_head.data};
                     after_len = 1'b1;
                  end
                  RP_IDLEN: begin
                     role     = ROLE_IDLEN;
                     idlen_in = q_head.data;
                     go_field = 1'b1;
                  end
                  RP_TYPE: begin
                     role    = ROLE_TYPE;
                     fcnt_in = fcnt_inc;
                     if (!(fcnt_inc < {24'd0, tlen_ff})) begin
                        go_field   = 1'b1;
                        allow_type = 1'b0;
                     end
                  end
                  RP_ID: begin
                     role    = ROLE_ID;
                     fcnt_in = fcnt_inc;
                     if (!(fcnt_inc < {24'd0, idlen_ff})) begin
                        go_field   = 1'b1;
                        allow_type = 1'b0;
                        allow_id   = 1'b0;
                     end
                  end
                  RP_PAY: begin
                     role    = ROLE_PAY;
                     fcnt_in = fcnt_inc;
                     if (!(fcnt_inc < plen_ff)) begin
                        complete = 1'b1;
                     end
                  end
                  default: begin
                     rec_ph_in = RP_HDR;
                  end
               endcase

               tlv_seen_in = tlv_seen_ff + 16'd1;
               if (tlv_seen_in >= tlv_len_ff) begin
                  tlv_ph_in = TP_TAG;
               end
            end
            default: begin
               tlv_ph_in = TP_TAG;
            end
         endcase

         if (!rep && q_head.buf_end) begin
            rep    = 1'b1;
            status = 1'b1;
         end
      end

      // Lengths done: read the ID length next, or pick the first data field.
      if (after_len) begin
         if (hdr_in[FLAG_IL_BIT]) begin
            rec_ph_in = RP_IDLEN;
         end else begin
            go_field = 1'b1;
         end
      end

      // Pass over empty fields; a record with nothing left completes here.
      if (go_field) begin
         fcnt_in = '0;
         if (allow_type && tlen_in != '0) begin
            rec_ph_in = RP_TYPE;
         end else if (allow_id && hdr_in[FLAG_IL_BIT] && idlen_in != '0) begin
            rec_ph_in = RP_ID;
         end else if (plen_in != '0) begin
            rec_ph_in = RP_PAY;
         end else begin
            complete = 1'b1;
         end
      end

      found_in = found_s;
      if (complete) begin
         rec_ph_in = RP_HDR;
         fcnt_in   = '0;
         done      = 1'b1;
         if (found_s < MAX_CNT) begin
            found_in = found_s + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlv_ph_ff    <= TP_TAG;
         rec_ph_ff    <= RP_HDR;
         tlv_len_ff   <= '0;
         tlv_seen_ff  <= '0;
         hdr_ff       <= '0;
         tlen_ff      <= '0;
         idlen_ff     <= '0;
         plen_ff      <= '0;
         fcnt_ff      <= '0;
         found_ff     <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            tlv_ph_ff   <= tlv_ph_in;
            rec_ph_ff   <= rec_ph_in;
            tlv_len_ff  <= tlv_len_in;
            tlv_seen_ff <= tlv_seen_in;
            hdr_ff      <= hdr_in;
            tlen_ff     <= tlen_in;
            idlen_ff    <= idlen_in;
            plen_ff     <= plen_in;
            fcnt_ff     <= fcnt_in;
            found_ff    <= found_in;
            fin_ff      <= fin_in;
         end
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_byte_role      <= role;
         rsp_record_index   <= found_s;
         rsp_record_done    <= done;
         rsp_header_byte    <= hdr_in;
         rsp_type_length    <= tlen_in;
         rsp_id_length      <= idlen_in;
         rsp_payload_length <= plen_in;
         rsp_report_valid   <= rep;
         rsp_report_status  <= rep & status;
         rsp_report_count   <= rep ? found_in : 8'd0;
      end
   end

endmodule
`default_nettype wire

[hdl/ndef_tlv_record_parser.sv]
// A byte accepted by the block is written into the queue; the back end then pops it
// and registers its result on rsp_, provided the result register is free or drained.
// Throughput: one byte per cycle while rsp_ready stays high; the back end parses each
// byte as it pops it, and a two-entry queue lets front and back stall on their own.
// Reset (synchronous, active high) empties the queue, drops any pending result,
// and returns the TLV and record walkers to "expect tag" / "expect header".
`default_nettype none
module ndef_tlv_record_parser
   import ntrp_pkg::*;
#(
   parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_buffer_start,
   input  wire logic        req_buffer_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_byte_role,
   output logic [7:0]       rsp_record_index,
   output logic             rsp_record_done,
   output logic [7:0]       rsp_header_byte,
   output logic [7:0]       rsp_type_length,
   output logic [7:0]       rsp_id_length,
   output logic [31:0]      rsp_payload_length,
   output logic             rsp_report_valid,
   output logic             rsp_report_status,
   output logic [7:0]       rsp_report_count
);

   // Front end: take a transaction and decode the tag, terminator and escape codes.
   logic     q_full;
   logic     q_push;
   item_type q_item;

   // Back end side of the queue.
   logic     q_pop;
   logic     q_not_empty;
   item_type q_head;

   ntrp_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_buffer_start (req_buffer_start),
      .req_buffer_end   (req_buffer_end),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_item)
   );

   // Hold decoded bytes until the parser can take them.
   ntrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // Back end: walk TLVs and NDEF records, advance only when the result
   // register is free or being drained this cycle.
   ntrp_back #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_role      (rsp_byte_role),
      .rsp_record_index   (rsp_record_index),
      .rsp_record_done    (rsp_record_done),
      .rsp_header_byte    (rsp_header_byte),
      .rsp_type_length    (rsp_type_length),
      .rsp_id_length      (rsp_id_length),
      .rsp_payload_length (rsp_payload_length),
      .rsp_report_valid   (rsp_report_valid),
      .rsp_report_status  (rsp_report_status),
      .rsp_report_count   (rsp_report_count)
   );

endmodule
`default_nettype wire

[hdl/ntrp_checker.sv]
`default_nettype none
module ntrp_checker
   import ntrp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_data_byte,
   input wire logic        req_buffer_start,
   input wire logic        req_buffer_end,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_byte_role,
   input wire logic [7:0]  rsp_record_index,
   input wire logic        rsp_record_done,
   input wire logic [7:0]  rsp_header_byte,
   input wire logic [7:0]  rsp_type_length,
   input wire logic [7:0]  rsp_id_length,
   input wire logic [31:0] rsp_payload_length,
   input wire logic        rsp_report_valid,
   input wire logic        rsp_report_status,
   input wire logic [7:0]  rsp_report_count
);

   // A terminator report must sit on the terminator byte itself.
   a_term_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_valid && !rsp_report_status
         |-> rsp_byte_role == ROLE_TERM)
      else $error("terminator report on a non-terminator byte");

   // Records complete only on a payload length, ID length or data byte.
   a_done_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_done
         |-> rsp_byte_role == ROLE_PAYLEN || rsp_byte_role == ROLE_IDLEN ||
             rsp_byte_role == ROLE_TYPE || rsp_byte_role == ROLE_ID ||
             rsp_byte_role == ROLE_PAY)
      else $error("record completed on an unexpected byte role");

   // No report, no count.
   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_valid |-> rsp_report_count == 8'd0 && !rsp_report_status)
      else $error("report fields set without a report");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_role) &&
         $stable(rsp_payload_length) && $stable(rsp_record_index))
      else $error("result changed while stalled");

endmodule

bind ndef_tlv_record_parser ntrp_checker u_ntrp_checker (.*);
`default_nettype wire

[bench/ndef_parse_monitor.sv]
`timescale 1ns / 1ps
module ndef_parse_monitor
   import ntrp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_buffer_start,
   input  wire logic        req_buffer_end,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [3:0]  rsp_byte_role,
   input  wire logic [7:0]  rsp_record_index,
   input  wire logic        rsp_record_done,
   input  wire logic [7:0]  rsp_header_byte,
   input  wire logic [7:0]  rsp_type_length,
   input  wire logic [7:0]  rsp_id_length,
   input  wire logic [31:0] rsp_payload_length,
   input  wire logic        rsp_report_valid,
   input  wire logic        rsp_report_status,
   input  wire logic [7:0]  rsp_report_count,
   output int               fail_count,
   output int               outcomes_pending
);

   typedef struct packed {
      role_type    role;
      logic [7:0]  index;
      logic        done;
      logic [7:0]  header;
      logic [7:0]  type_len;
      logic [7:0]  id_len;
      logic [31:0] pay_len;
      logic        rep_valid;
      logic        rep_status;
      logic [7:0]  rep_count;
   } byte_outcome_type;

   byte_outcome_type outcomes_due[$];

   // Parser state as the block should hold it.
   tlv_phase_type frame_state;
   rec_phase_type walk_state;
   logic [15:0]   tlv_len;
   logic [15:0]   tlv_seen;
   logic [7:0]    hdr;
   logic [7:0]    tlen;
   logic [7:0]    idlen;
   logic [31:0]   plen;
   logic [31:0]   field_cnt;
   logic [7:0]    rec_count;
   logic          msg_done;

   function automatic bit close_record();
      walk_state = RP_HDR;
      field_cnt  = '0;
      if (rec_count < MAX_RECORDS_DEF) rec_count++;
      return 1'b1;
   endfunction

   // Pick the first non-empty data field at or after the given one.
   function automatic bit pick_field(input rec_phase_type from);
      field_cnt = '0;
      if (from <= RP_TYPE && tlen != 0) begin
         walk_state = RP_TYPE;
         return 1'b0;
      end
      if (from <= RP_ID && hdr[FLAG_IL_BIT] && idlen != 0) begin
         walk_state = RP_ID;
         return 1'b0;
      end
      if (plen != 0) begin
         walk_state = RP_PAY;
         return 1'b0;
      end
      return close_record();
   endfunction

   function automatic bit lengths_read();
      if (hdr[FLAG_IL_BIT]) begin
         walk_state = RP_IDLEN;
         return 1'b0;
      end
      return pick_field(RP_TYPE);
   endfunction

   function automatic bit walk_record(input logic [7:0] b, output role_type role);
      case (walk_state)
         RP_HDR: begin
            role       = ROLE_HDR;
            hdr        = b;
            tlen       = '0;
            idlen      = '0;
            plen       = '0;
            field_cnt  = '0;
            walk_state = RP_TLEN;
            return 1'b0;
         end
         RP_TLEN: begin
            role       = ROLE_TYPELEN;
            tlen       = b;
            walk_state = RP_PL0;
            return 1'b0;
         end
         RP_PL0: begin
            role = ROLE_PAYLEN;
            plen = {24'd0, b};
            if (!hdr[FLAG_SR_BIT]) begin
               walk_state = RP_PL1;
               return 1'b0;
            end
            return lengths_read();
         end
         RP_PL1, RP_PL2, RP_PL3: begin
            role = ROLE_PAYLEN;
            plen = {plen[23:0], b};
            if (walk_state == RP_PL3) return lengths_read();
            walk_state = rec_phase_type'(walk_state + 1);
            return 1'b0;
         end
         RP_IDLEN: begin
            role  = ROLE_IDLEN;
            idlen = b;
            return pick_field(RP_TYPE);
         end
         RP_TYPE: begin
            role = ROLE_TYPE;
            field_cnt++;
            if (field_cnt < tlen) return 1'b0;
            return pick_field(RP_ID);
         end
         RP_ID: begin
            role = ROLE_ID;
            field_cnt++;
            if (field_cnt < idlen) return 1'b0;
            return pick_field(RP_PAY);
         end
         RP_PAY: begin
            role = ROLE_PAY;
            field_cnt++;
            if (field_cnt < plen) return 1'b0;
            return close_record();
         end
         default: begin
            role       = ROLE_SKIP;
            walk_state = RP_HDR;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic byte_outcome_type classify_byte(input logic [7:0] b,
                                                      input logic first,
                                                      input logic last);
      byte_outcome_type r;
      role_type      role;
      logic          done;
      logic          rep;
      logic          status;
      logic [7:0]    idx;
      role   = ROLE_SKIP;
      done   = 1'b0;
      rep    = 1'b0;
      status = 1'b0;
      if (first) begin
         rec_count = '0;
         msg_done  = 1'b0;
      end
      idx = rec_count;
      if (!msg_done) begin
         case (frame_state)
            TP_TAG: begin
               if (b == TLV_TAG) begin
                  role        = ROLE_TAG;
                  tlv_seen    = '0;
                  frame_state = TP_L0;
               end else if (b == TLV_TERM) begin
                  role     = ROLE_TERM;
                  msg_done = 1'b1;
                  rep      = 1'b1;
               end
            end
            TP_L0: begin
               role = ROLE_TLEN;
               if (b == TLV_LONG) begin
                  tlv_len     = '0;
                  frame_state = TP_L1;
               end else begin
                  tlv_len     = {8'd0, b};
                  frame_state = (b != 0) ? TP_VAL : TP_TAG;
               end
            end
            TP_L1: begin
               role        = ROLE_TLEN;
               tlv_len     = {8'd0, b};
               frame_state = TP_L2;
            end
            TP_L2: begin
               role        = ROLE_TLEN;
               tlv_len     = {tlv_len[7:0], b};
               frame_state = (tlv_len != 0) ? TP_VAL : TP_TAG;
            end
            TP_VAL: begin
               done     = walk_record(b, role);
               tlv_seen = tlv_seen + 16'd1;
               if (tlv_seen >= tlv_len) frame_state = TP_TAG;
            end
            default: frame_state = TP_TAG;
         endcase
         if (!rep && last) begin
            rep    = 1'b1;
            status = 1'b1;
         end
      end
      r.role       = role;
      r.index      = idx;
      r.done       = done;
      r.header     = hdr;
      r.type_len   = tlen;
      r.id_len     = idlen;
      r.pay_len    = plen;
      r.rep_valid  = rep;
      r.rep_status = rep ? status : 1'b0;
      r.rep_count  = rep ? rec_count : 8'd0;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      byte_outcome_type want;
      if (reset) begin
         frame_state = TP_TAG;
         walk_state  = RP_HDR;
         tlv_len     = '0;
         tlv_seen    = '0;
         hdr         = '0;
         tlen        = '0;
         idlen       = '0;
         plen        = '0;
         field_cnt   = '0;
         rec_count   = '0;
         msg_done    = 1'b0;
         outcomes_due.delete();
      end else begin
         // retire the oldest expectation before adding this edge's transaction
         if (rsp_valid && rsp_ready) begin
            if (outcomes_due.size() == 0) begin
               $error("result transaction with no expected outcome pending");
               fail_count++;
            end else begin
               want = outcomes_due.pop_front();
               check_field("byte_role", 32'(want.role), 32'(rsp_byte_role));
               check_field("record_index", 32'(want.index), 32'(rsp_record_index));
               check_field("record_done", 32'(want.done), 32'(rsp_record_done));
               check_field("header_byte", 32'(want.header), 32'(rsp_header_byte));
               check_field("type_length", 32'(want.type_len), 32'(rsp_type_length));
               check_field("id_length", 32'(want.id_len), 32'(rsp_id_length));
               check_field("payload_length", want.pay_len, rsp_payload_length);
               check_field("report_valid", 32'(want.rep_valid), 32'(rsp_report_valid));
               check_field("report_status", 32'(want.rep_status),
                           32'(rsp_report_status));
               check_field("report_count", 32'(want.rep_count), 32'(rsp_report_count));
            end
         end
         if (req_valid && req_ready)
            outcomes_due.push_back(classify_byte(req_data_byte, req_buffer_start,
                                                 req_buffer_end));
      end
      outcomes_pending <= outcomes_due.size();
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import ntrp_pkg::*;

   localparam int CLOCK_HALF      = 4;
   localparam int ITEM_TARGET     = 1375;  // directed bytes plus the random stream
   localparam int QUIET_ITEMS     = 150;   // final stretch with both sides always ready
   localparam int PRESSURE_AT     = 800;   // cycle at which the receiver holds off long
   localparam int PRESSURE_CYCLES = 90;
   localparam int STALL_LIMIT     = 1000;  // cycles without any transaction
   localparam int DRAIN_CYCLES    = 8;
   localparam int FLOOD_BUFFER    = 6;     // buffer that carries enough records to saturate
   localparam int FLOOD_BYTES     = 450;
   localparam int FLOOD_TLV_LEN   = 240;

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte      = 8'h00;
   logic        req_buffer_start   = 1'b0;
   logic        req_buffer_end     = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [3:0]  rsp_byte_role;
   logic [7:0]  rsp_record_index;
   logic        rsp_record_done;
   logic [7:0]  rsp_header_byte;
   logic [7:0]  rsp_type_length;
   logic [7:0]  rsp_id_length;
   logic [31:0] rsp_payload_length;
   logic        rsp_report_valid;
   logic        rsp_report_status;
   logic [7:0]  rsp_report_count;

   int          mismatches;
   int          results_due;

   // Well-formed NDEF record bytes waiting to be wrapped into TLV values. Keeping the
   // record stream separate from the TLV framing lets records straddle TLV and buffer
   // boundaries while the block's record walker never loses alignment.
   logic [7:0]  record_bytes[$];
   // Bytes framed for the wire; whatever a buffer end cuts off carries into the next buffer.
   logic [7:0]  wire_bytes[$];
   int          items_sent;
   bit          quiet_tail;
   bit          flood_mode;

   ndef_tlv_record_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_buffer_start   (req_buffer_start),
      .req_buffer_end     (req_buffer_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_role      (rsp_byte_role),
      .rsp_record_index   (rsp_record_index),
      .rsp_record_done    (rsp_record_done),
      .rsp_header_byte    (rsp_header_byte),
      .rsp_type_length    (rsp_type_length),
      .rsp_id_length      (rsp_id_length),
      .rsp_payload_length (rsp_payload_length),
      .rsp_report_valid   (rsp_report_valid),
      .rsp_report_status  (rsp_report_status),
      .rsp_report_count   (rsp_report_count)
   );

   ndef_parse_monitor parse_monitor (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_buffer_start   (req_buffer_start),
      .req_buffer_end     (req_buffer_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_role      (rsp_byte_role),
      .rsp_record_index   (rsp_record_index),
      .rsp_record_done    (rsp_record_done),
      .rsp_header_byte    (rsp_header_byte),
      .rsp_type_length    (rsp_type_length),
      .rsp_id_length      (rsp_id_length),
      .rsp_payload_length (rsp_payload_length),
      .rsp_report_valid   (rsp_report_valid),
      .rsp_report_status  (rsp_report_status),
      .rsp_report_count   (rsp_report_count),
      .fail_count         (mismatches),
      .outcomes_pending   (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic void push_field(input int count);
      repeat (count) record_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Append one NDEF record: random flags and TNF, small fields with the odd long one.
   function automatic void queue_record();
      logic [7:0]  hdr;
      logic [7:0]  type_len;
      logic [7:0]  id_len;
      logic [31:0] pay_len;
      if (flood_mode) begin
         // empty short record: three bytes, completes on its payload length byte
         hdr = 8'($urandom_range(0, 255));
         hdr[FLAG_SR_BIT] = 1'b1;
         hdr[FLAG_IL_BIT] = 1'b0;
         record_bytes.push_back(hdr);
         record_bytes.push_back(8'h00);
         record_bytes.push_back(8'h00);
         return;
      end
      hdr      = 8'($urandom_range(0, 255));
      type_len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 40))
                                             : 8'($urandom_range(0, 4));
      id_len   = hdr[FLAG_IL_BIT] ? 8'($urandom_range(0, 3)) : 8'd0;
      if ($urandom_range(0, 5) == 0)
         pay_len = 32'd0;
      else if (hdr[FLAG_SR_BIT])
         pay_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 255)
                                                : $urandom_range(1, 12);
      else
         pay_len = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 330)
                                                : $urandom_range(1, 12);
      record_bytes.push_back(hdr);
      record_bytes.push_back(type_len);
      if (hdr[FLAG_SR_BIT]) begin
         record_bytes.push_back(pay_len[7:0]);
      end else begin
         record_bytes.push_back(pay_len[31:24]);
         record_bytes.push_back(pay_len[23:16]);
         record_bytes.push_back(pay_len[15:8]);
         record_bytes.push_back(pay_len[7:0]);
      end
      if (hdr[FLAG_IL_BIT]) record_bytes.push_back(id_len);
      push_field(int'(type_len));
      push_field(int'(id_len));
      push_field(int'(pay_len));
   endfunction

   // Frame the next wire unit: a stray byte between TLVs, or a whole NDEF TLV.
   function automatic void queue_frame();
      logic [15:0] len;
      logic [7:0]  stray;
      bit          long_form;
      if (!flood_mode && $urandom_range(0, 2) == 0) begin
         // anything but a tag or a terminator is skipped outside a TLV
         do stray = 8'($urandom_range(0, 255));
         while (stray == TLV_TAG || stray == TLV_TERM);
         wire_bytes.push_back(stray);
         return;
      end
      if (flood_mode)
         len = 16'(FLOOD_TLV_LEN);
      else if ($urandom_range(0, 7) == 0)
         len = 16'd0;
      else if ($urandom_range(0, 14) == 0)
         len = 16'($urandom_range(200, 320));
      else
         len = 16'($urandom_range(1, 30));
      long_form = (len > 254) || ($urandom_range(0, 4) == 0);
      wire_bytes.push_back(TLV_TAG);
      if (long_form) begin
         wire_bytes.push_back(TLV_LONG);
         wire_bytes.push_back(len[15:8]);
         wire_bytes.push_back(len[7:0]);
      end else begin
         wire_bytes.push_back(len[7:0]);
      end
      while (record_bytes.size() < len) queue_record();
      repeat (len) wire_bytes.push_back(record_bytes.pop_front());
   endfunction

   // Offer one byte and hold it until the block takes the transaction.
   task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
      if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_buffer_start <= first;
      req_buffer_end   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // One buffer: body_len framed bytes, cut wherever they fall, then optionally
   // the rest of any open TLV, a terminator and a few skipped trailing bytes.
   task automatic send_buffer(input int body_len, input bit with_term);
      int sent;
      int junk;
      bit first;
      sent  = 0;
      first = 1'b1;
      while (sent < body_len || (with_term && wire_bytes.size() != 0)) begin
         if (wire_bytes.size() == 0) queue_frame();
         send_byte(wire_bytes.pop_front(), first, !with_term && sent == body_len - 1);
         first = 1'b0;
         sent++;
      end
      if (with_term) begin
         junk = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
         send_byte(TLV_TERM, first, junk == 0);
         for (int i = 0; i < junk; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, i == junk - 1);
      end
   endtask

   // Receiver: random stall bursts, one long hold-off to fill the block, none at the end.
   initial begin
      int cycle;
      cycle = 0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle == PRESSURE_AT) begin
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if no transaction moves on either channel for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int buffers;
      int body_len;
      bit with_term;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed buffer: skipped extremes, empty TLVs in both length forms, a record
      // with IL set and ID length zero that completes on its last length byte, a
      // 4-byte payload length, a record split across two TLVs, terminator on last byte.
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(TLV_TAG, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(TLV_TAG, 1'b0, 1'b0);
      send_byte(TLV_LONG, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(TLV_TAG, 1'b0, 1'b0);
      send_byte(8'h0A, 1'b0, 1'b0);
      send_byte(8'h19, 1'b0, 1'b0);   // SR, IL, TNF well-known
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);   // long record, no flags
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(TLV_TAG, 1'b0, 1'b0);
      send_byte(8'h02, 1'b0, 1'b0);
      send_byte(8'h55, 1'b0, 1'b0);   // type byte carried into the next TLV
      send_byte(8'hAA, 1'b0, 1'b0);   // payload byte completes the record
      send_byte(TLV_TERM, 1'b0, 1'b1);

      // Random buffers, one of them packed with enough records to saturate the count.
      buffers = 0;
      while (items_sent < ITEM_TARGET) begin
         with_term = 1'($urandom_range(0, 1));
         if (buffers == FLOOD_BUFFER) begin
            flood_mode = 1'b1;
            send_buffer(FLOOD_BYTES, 1'b1);
            flood_mode = 1'b0;
         end else begin
            body_len = ($urandom_range(0, 7) == 0) ? (with_term ? 0 : 1)
                                                   : $urandom_range(2, 40);
            send_buffer(body_len, with_term);
         end
         buffers++;
      end

      // Drop valid, let the last transaction reach the count, drain outstanding
      // results, then allow the pipeline to settle.
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_due == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
